@@ hdl/segment_pair_distance_squared_top_assert.svh @@
// Assertion macros shared by the segment distance design.
`ifndef SEGMENT_PAIR_DISTANCE_SQUARED_TOP_ASSERT_SVH
`define SEGMENT_PAIR_DISTANCE_SQUARED_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/spd_pkg.sv @@
`default_nettype none
package spd_pkg;
  localparam int OUT_BITS = 41;
  // Case of a point against a segment.
  typedef enum logic [2:0] {
    PS_START = 3'b001,
    PS_END   = 3'b010,
    PS_MID   = 3'b100
  } ps_case_t;
endpackage
`default_nettype wire

@@ hdl/spd_divider.sv @@
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
module spd_divider #(
  parameter int NUM_BITS = 8,
  parameter int DEN_BITS = 8,
  parameter int Q_BITS   = 8
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic      [Q_BITS-1:0]   quo
);
  localparam int REM_BITS = DEN_BITS + 1;

  logic [REM_BITS-1:0] rem [Q_BITS+1];
  logic [NUM_BITS-1:0] nsh [Q_BITS+1];
  logic [DEN_BITS-1:0] dd  [Q_BITS+1];
  logic [Q_BITS-1:0]   qq  [Q_BITS+1];

  // Numerator bits above the quotient window leave a remainder below den,
  // since the quotient is known to fit in Q_BITS.
  always_comb begin
    rem[0] = REM_BITS'(num[Q_BITS +: DEN_BITS]);
    nsh[0] = num << (NUM_BITS - Q_BITS);
    dd[0]  = den;
    qq[0]  = '0;
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic [REM_BITS-1:0] trial;
    assign trial = {rem[i][DEN_BITS-1:0], nsh[i][NUM_BITS-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dd[i+1]  <= dd[i];
        nsh[i+1] <= nsh[i] << 1;
        if (trial >= REM_BITS'(dd[i])) begin
          rem[i+1] <= trial - REM_BITS'(dd[i]);
          qq[i+1]  <= {qq[i][Q_BITS-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial;
          qq[i+1]  <= {qq[i][Q_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qq[Q_BITS];
endmodule
`default_nettype wire

@@ hdl/segment_pair_distance_squared_top.sv @@
// An accepted input runs through the capture, difference, product, sum, cross
// square, divider (QUO_BITS = 2*COORD_BITS + 3 + FRAC_BITS bits) and minimum
// stages to the output register. Throughput: one transaction per cycle unless
// the output stalls; the divider's depth sets the latency, not the rate.
// Reset: rst is synchronous and active high; it clears all valid bits.
`default_nettype none
`include "segment_pair_distance_squared_top_assert.svh"
module segment_pair_distance_squared_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
  // b_end_x, b_end_y from the lowest bit up, zero filled to whole bytes.
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // dist_sq, zero filled to 48 bits.
  output logic [47:0] m_tdata
);
  import spd_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DB   = CB + 1;        // coordinate difference
  localparam int LB   = 2 * DB + 1;    // squared length
  localparam int CRB  = 2 * DB + 2;    // cross or dot product
  localparam int SQB  = 2 * CRB;       // cross squared
  localparam int NB   = SQB + FRAC_BITS;
  localparam int QB   = LB + FRAC_BITS; // quotient bound: interior dist <= |ap|^2
  localparam int DEP  = QB + 7;
  localparam int WB   = (QB > OUT_BITS) ? QB : OUT_BITS;

  // One valid bit per pipeline stage; the whole pipe moves when the output
  // register is free or being emptied.
  logic [DEP-1:0] vld;
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEP-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[DEP-1];

  // Stage 1: capture coordinates.
  logic signed [CB-1:0] cx [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        cx[i] <= s_tdata[i*CB +: CB];
      end
    end
  end

  // Point order per check: p, s, e as indexes into cx (x at even index).
  function automatic int pidx(input int k, input int r);
    int t;
    begin
      t = 0;
      case (k)
        0: t = (r == 0) ? 0 : (r == 1) ? 4 : 6;
        1: t = (r == 0) ? 2 : (r == 1) ? 4 : 6;
        2: t = (r == 0) ? 4 : (r == 1) ? 0 : 2;
        default: t = (r == 0) ? 6 : (r == 1) ? 0 : 2;
      endcase
      return t;
    end
  endfunction

  logic [WB-1:0] cand [4];

  for (genvar k = 0; k < 4; k++) begin : g_chk
    localparam int P = pidx(k, 0);
    localparam int S = pidx(k, 1);
    localparam int E = pidx(k, 2);
    // Stage 2: differences.
    logic signed [DB-1:0] abx, aby, apx, apy, bpx, bpy;
    always_ff @(posedge clk) begin
      if (adv) begin
        abx <= DB'(cx[E])   - DB'(cx[S]);
        aby <= DB'(cx[E+1]) - DB'(cx[S+1]);
        apx <= DB'(cx[P])   - DB'(cx[S]);
        apy <= DB'(cx[P+1]) - DB'(cx[S+1]);
        bpx <= DB'(cx[P])   - DB'(cx[E]);
        bpy <= DB'(cx[P+1]) - DB'(cx[E+1]);
      end
    end
    // Stage 3: products.
    logic signed [2*DB-1:0] m_ab [2], m_ap [2], m_bp [2], m_d [2], m_c [2];
    always_ff @(posedge clk) begin
      if (adv) begin
        m_ab[0] <= abx * abx;  m_ab[1] <= aby * aby;
        m_ap[0] <= apx * apx;  m_ap[1] <= apy * apy;
        m_bp[0] <= bpx * bpx;  m_bp[1] <= bpy * bpy;
        m_d[0]  <= apx * abx;  m_d[1]  <= apy * aby;
        m_c[0]  <= apx * aby;  m_c[1]  <= apy * abx;
      end
    end
    // Stage 4: sums and case choice.
    logic [LB-1:0] len, dap, dbp;
    logic signed [CRB-1:0] dot, crs;
    always_ff @(posedge clk) begin
      if (adv) begin
        len <= LB'(unsigned'(m_ab[0])) + LB'(unsigned'(m_ab[1]));
        dap <= LB'(unsigned'(m_ap[0])) + LB'(unsigned'(m_ap[1]));
        dbp <= LB'(unsigned'(m_bp[0])) + LB'(unsigned'(m_bp[1]));
        dot <= CRB'(m_d[0]) + CRB'(m_d[1]);
        crs <= CRB'(m_c[0]) - CRB'(m_c[1]);
      end
    end
    ps_case_t pc_c;
    logic [CRB-1:0] cmag;
    always_comb begin
      if (len == '0 || dot <= 0) begin
        pc_c = PS_START;
      end else if (unsigned'(dot) >= CRB'(len)) begin
        pc_c = PS_END;
      end else begin
        pc_c = PS_MID;
      end
      cmag = crs[CRB-1] ? CRB'(-crs) : CRB'(crs);
    end
    // Stage 5: square the cross product; end-point distances set aside.
    ps_case_t pc5;
    logic [LB-1:0] len5, ed5;
    logic [SQB-1:0] csq;
    always_ff @(posedge clk) begin
      if (adv) begin
        pc5  <= pc_c;
        len5 <= (len == '0) ? LB'(1) : len;
        ed5  <= (pc_c == PS_END) ? dbp : dap;
        csq  <= cmag * cmag;
      end
    end
    // Divider stages, with the end-point result and case riding alongside.
    logic [QB-1:0] q;
    spd_divider #(.NUM_BITS(NB), .DEN_BITS(LB), .Q_BITS(QB)) u_div (
      .clk(clk), .adv(adv),
      .num({csq, {FRAC_BITS{1'b0}}}),
      .den(len5), .quo(q)
    );
    logic          dmid [QB+1];
    logic [LB-1:0] ded  [QB+1];
    assign dmid[0] = (pc5 == PS_MID);
    assign ded[0]  = ed5;
    for (genvar j = 0; j < QB; j++) begin : g_side
      always_ff @(posedge clk) begin
        if (adv) begin
          dmid[j+1] <= dmid[j];
          ded[j+1]  <= ded[j];
        end
      end
    end
    always_comb begin
      if (dmid[QB]) begin
        cand[k] = WB'(q);
      end else begin
        cand[k] = WB'({ded[QB], {FRAC_BITS{1'b0}}});
      end
    end
  end

  // Two stages of minimum, the second being the output register.
  logic [WB-1:0] mn0, mn1, best;
  always_ff @(posedge clk) begin
    if (adv) begin
      mn0  <= (cand[1] < cand[0]) ? cand[1] : cand[0];
      mn1  <= (cand[3] < cand[2]) ? cand[3] : cand[2];
      best <= (mn1 < mn0) ? mn1 : mn0;
    end
  end
  assign m_tdata = {7'd0, best[OUT_BITS-1:0]};

  `SPD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "stalled result changed")
  `SPD_ASSERT_IMP(a_ready, clk, rst, m_tvalid && !m_tready, !s_tready,
    "input taken while output stalled")
  `SPD_ASSERT_NEXT(a_move, clk, rst, s_tready && s_tvalid, vld[0],
    "accepted transaction lost its valid bit")
endmodule
`default_nettype wire
